// ----- hdl/fgr_pkg.sv -----
// Shared types, constants and font table of the glyph rectangle rasteriser.
`default_nettype none
package fgr_pkg;

	localparam int unsigned GLYPH_COLS  = 5;
	localparam int unsigned GLYPH_ROWS  = 8;
	localparam int unsigned GLYPH_COUNT = 59;
	localparam logic [7:0]  FIRST_CODE  = 8'd32;
	localparam logic [7:0]  LAST_CODE   = 8'd90;
	localparam logic [7:0]  LOWER_A     = 8'd97;
	localparam logic [7:0]  LOWER_Z     = 8'd122;
	localparam logic [7:0]  CASE_OFFSET = 8'd32;

	localparam logic [2:0]  LAST_COL    = 3'd5;
	localparam logic [2:0]  LAST_ROW    = 3'd7;

	localparam logic [10:0] SCREEN_WIDTH_RESET  = 11'd240;
	localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd320;

	// register indexes on the configuration port
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0]  char_code;
		logic [9:0]  x_pos;
		logic [9:0]  y_pos;
		logic [15:0] fg_color;
		logic [15:0] bg_color;
		logic [7:0]  scale;
	} char_word_t;

	typedef struct packed {
		logic [11:0] rect_x;
		logic [11:0] rect_y;
		logic [10:0] rect_w;
		logic [10:0] rect_h;
		logic [15:0] rect_color;
		logic        visible;
		logic        last;
	} rect_word_t;

	// unclipped rectangle handed to the clipping stage
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [10:0] w;
		logic [10:0] h;
		logic [15:0] color;
		logic        last;
	} rect_pre_t;

	typedef logic [7:0] glyph_col_t;

	// column bytes, bit 0 is the top row
	localparam glyph_col_t FONT_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
		'{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
		'{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
		'{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
		'{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
		'{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
		'{8'h08,8'h2A,8'h1C,8'h2A,8'h08}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
		'{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
		'{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
		'{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
		'{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
		'{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
		'{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
		'{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
		'{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
		'{8'h00,8'h08,8'h14,8'h22,8'h41}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
		'{8'h41,8'h22,8'h14,8'h08,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
		'{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
		'{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
		'{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
		'{8'h7F,8'h09,8'h09,8'h01,8'h01}, '{8'h3E,8'h41,8'h41,8'h51,8'h32},
		'{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
		'{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
		'{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F},
		'{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
		'{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
		'{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
		'{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
		'{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
		'{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h03,8'h04,8'h78,8'h04,8'h03},
		'{8'h61,8'h51,8'h49,8'h45,8'h43}
	};

	// fold lower case to upper case, map any code outside the font's span to space
	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [7:0] c;
		c = code;
		if (c >= LOWER_A && c <= LOWER_Z) begin
			c = c - CASE_OFFSET;
		end
		if (c < FIRST_CODE || c > LAST_CODE) begin
			c = FIRST_CODE;
		end
		glyph_index = 6'(c - FIRST_CODE);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/fgr_clip.sv -----
// Clips one rectangle to the display and forms the result word.
`default_nettype none
module fgr_clip
	import fgr_pkg::*;
(
	input  wire rect_pre_t   pre,
	input  wire logic [10:0] screen_width,
	input  wire logic [10:0] screen_height,
	output rect_word_t       result
);

	logic [12:0] x_ext;
	logic [12:0] y_ext;
	logic [12:0] dw_ext;
	logic [12:0] dh_ext;
	logic [12:0] x_end;
	logic [12:0] y_end;
	logic        on_screen;

	always_comb begin
		x_ext     = {1'b0, pre.x};
		y_ext     = {1'b0, pre.y};
		dw_ext    = {2'b00, screen_width};
		dh_ext    = {2'b00, screen_height};
		x_end     = x_ext + {2'b00, pre.w};
		y_end     = y_ext + {2'b00, pre.h};
		on_screen = (x_ext < dw_ext) && (y_ext < dh_ext) && (pre.w != '0) && (pre.h != '0);

		result.rect_x     = pre.x;
		result.rect_y     = pre.y;
		result.rect_color = pre.color;
		result.last       = pre.last;
		result.visible    = on_screen;
		result.rect_w     = '0;
		result.rect_h     = '0;
		if (on_screen) begin
			// cut any overhang at the right and bottom edges
			result.rect_w = (x_end > dw_ext) ? 11'(dw_ext - x_ext) : pre.w;
			result.rect_h = (y_end > dh_ext) ? 11'(dh_ext - y_ext) : pre.h;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/font_glyph_rect_rasterizer.sv -----
// Top level of the glyph rectangle rasteriser: input buffer, sequencer, font read, output.
//
// Usage
//   char_* channel: one word per character (code, cell position, colours, scale).
//   rect_* channel: 41 rectangle words per character, in column order, eight
//   rows per column, then one trailing background column flagged by last.
//   APB port: register 0 screen width at 0x0, register 1 screen height at 0x4,
//   low 11 bits kept; write only while no character is in flight.
// Timing
//   One rectangle leaves per cycle while the receiver takes them; a character
//   is 41 rectangles, stepped out by the row/column sequencer.
//   The first rectangle reaches rect_word after the sequencer load, the font
//   ROM read and the clip/output register.
//   A one-word buffer takes the next character while the current one is
//   drawn, so characters follow without a gap.
// Reset and stall
//   Reset empties the buffer and pipeline and restores 240 x 320.
//   A stalled receiver freezes the sequencer, ROM read and output word; the
//   buffer still takes one further character.
`default_nettype none
module font_glyph_rect_rasterizer
	import fgr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// character channel
	input  wire logic        char_valid,
	output logic             char_ready,
	input  wire char_word_t  char_word,
	// rectangle channel
	output logic             rect_valid,
	input  wire logic        rect_ready,
	output rect_word_t       rect_word,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// configuration registers
	logic [10:0] screen_width_q;
	logic [10:0] screen_height_q;

	// one-word input buffer
	char_word_t  pend_q;
	logic        pend_valid_q;

	// sequencer state for the character being drawn
	logic        active_q;
	logic [2:0]  col_q;
	logic [2:0]  row_q;
	logic [5:0]  glyph_q;
	logic [9:0]  x_q;
	logic [9:0]  y_q;
	logic [15:0] fg_q;
	logic [15:0] bg_q;
	logic [7:0]  scale_q;
	logic [10:0] xoff_q;
	logic [10:0] yoff_q;

	// font read stage
	logic        valid_s1;
	glyph_col_t  bits_s1;
	logic [2:0]  row_s1;
	logic [11:0] x_s1;
	logic [11:0] y_s1;
	logic [10:0] w_s1;
	logic [10:0] h_s1;
	logic [15:0] fg_s1;
	logic [15:0] bg_s1;
	logic        last_s1;

	logic        out_valid_q;
	rect_word_t  out_q;

	logic        advance;
	logic        seq_last;
	logic        load;
	logic        cfg_write;
	rect_pre_t   pre;
	rect_word_t  clipped;

	assign advance    = !out_valid_q || rect_ready;
	assign seq_last   = (col_q == LAST_COL);
	assign load       = pend_valid_q && (!active_q || (advance && seq_last));
	assign char_ready = !pend_valid_q;
	assign cfg_write  = psel && penable && pwrite;

	assign pready     = 1'b1;
	assign rect_valid = out_valid_q;
	assign rect_word  = out_q;

	// configuration write and read back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RESET;
			screen_height_q <= SCREEN_HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[10:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCREEN_WIDTH:  prdata = {21'd0, screen_width_q};
			REG_SCREEN_HEIGHT: prdata = {21'd0, screen_height_q};
			default:           prdata = '0;
		endcase
	end

	// input buffer: hold one word until the sequencer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (char_valid && char_ready) begin
			pend_valid_q <= 1'b1;
		end else if (load) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			pend_q <= char_word;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			col_q    <= '0;
			row_q    <= '0;
		end else if (active_q && advance) begin
			if (seq_last) begin
				active_q <= 1'b0;
			end else if (row_q == LAST_ROW) begin
				col_q <= col_q + 3'd1;
				row_q <= '0;
			end else begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	// sequencer payload: offsets advance by one scale step per row and column
	always_ff @(posedge clk) begin
		if (load) begin
			glyph_q <= glyph_index(pend_q.char_code);
			x_q     <= pend_q.x_pos;
			y_q     <= pend_q.y_pos;
			fg_q    <= pend_q.fg_color;
			bg_q    <= pend_q.bg_color;
			scale_q <= pend_q.scale;
			xoff_q  <= '0;
			yoff_q  <= '0;
		end else if (active_q && advance && !seq_last) begin
			if (row_q == LAST_ROW) begin
				xoff_q <= xoff_q + {3'd0, scale_q};
				yoff_q <= '0;
			end else begin
				yoff_q <= yoff_q + {3'd0, scale_q};
			end
		end
	end

	// font ROM read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && active_q) begin
			// the trailing column reads as empty, so it takes the background colour
			if (seq_last) begin
				bits_s1 <= '0;
			end else begin
				bits_s1 <= FONT_ROM[glyph_q][col_q];
			end
			row_s1  <= row_q;
			x_s1    <= {2'b00, x_q} + {1'b0, xoff_q};
			y_s1    <= {2'b00, y_q} + {1'b0, yoff_q};
			w_s1    <= {3'd0, scale_q};
			h_s1    <= seq_last ? {scale_q, 3'd0} : {3'd0, scale_q};
			fg_s1   <= fg_q;
			bg_s1   <= bg_q;
			last_s1 <= seq_last;
		end
	end

	always_comb begin
		pre.x     = x_s1;
		pre.y     = y_s1;
		pre.w     = w_s1;
		pre.h     = h_s1;
		pre.color = bits_s1[row_s1] ? fg_s1 : bg_s1;
		pre.last  = last_s1;
	end

	fgr_clip u_clip (
		.pre           (pre),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.result        (clipped)
	);

	// output register: hold the word while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= clipped;
		end
	end

endmodule
`default_nettype wire

// ----- sim/font_glyph_rect_rasterizer_tb.sv -----
// Self-checking testbench for the glyph rectangle rasteriser: random and directed characters.
`timescale 1ns / 1ps

import fgr_pkg::*;

// Holds the rectangles still owed by the block and compares arrivals against them.
class rect_scoreboard;
	rect_word_t  expected_rects[$];
	int unsigned disp_w;
	int unsigned disp_h;
	int unsigned rects_seen;

	function new();
		disp_w     = 240;
		disp_h     = 320;
		rects_seen = 0;
	endfunction

	function void set_display(input int unsigned w, input int unsigned h);
		disp_w = w;
		disp_h = h;
	endfunction

	function int pending();
		return expected_rects.size();
	endfunction

	function rect_word_t clip_rect(input int unsigned rx, input int unsigned ry,
			input int unsigned rw, input int unsigned rh, input logic [15:0] colour,
			input logic is_last);
		rect_word_t r;
		r.rect_x     = 12'(rx);
		r.rect_y     = 12'(ry);
		r.rect_color = colour;
		r.last       = is_last;
		if (rx >= disp_w || ry >= disp_h || rw == 0 || rh == 0) begin
			r.visible = 1'b0;
			r.rect_w  = '0;
			r.rect_h  = '0;
		end else begin
			if (rx + rw > disp_w) begin
				rw = disp_w - rx;
			end
			if (ry + rh > disp_h) begin
				rh = disp_h - ry;
			end
			r.visible = 1'b1;
			r.rect_w  = 11'(rw);
			r.rect_h  = 11'(rh);
		end
		return r;
	endfunction

	// glyph holds column 0 in its top byte
	function void note_char(input char_word_t c, input logic [39:0] glyph);
		logic [7:0]  bits;
		int unsigned s;
		int unsigned x;
		int unsigned y;
		s = c.scale;
		x = c.x_pos;
		y = c.y_pos;
		for (int col = 0; col < GLYPH_COLS; col++) begin
			bits = glyph[39 - 8 * col -: 8];
			for (int row = 0; row < GLYPH_ROWS; row++) begin
				expected_rects.push_back(clip_rect(x + col * s, y + row * s, s, s,
					bits[row] ? c.fg_color : c.bg_color, 1'b0));
			end
		end
		expected_rects.push_back(clip_rect(x + GLYPH_COLS * s, y, s, GLYPH_ROWS * s,
			c.bg_color, 1'b1));
	endfunction

	function bit check_rect(input rect_word_t got, output string msg);
		rect_word_t want;
		rects_seen++;
		msg = "";
		if (expected_rects.size() == 0) begin
			msg = $sformatf("rect %0d arrived with none outstanding (x=%0d y=%0d)",
				rects_seen - 1, got.rect_x, got.rect_y);
			return 1'b0;
		end
		want = expected_rects.pop_front();
		if (got.rect_x !== want.rect_x)
			msg = {msg, $sformatf(" x %0d/%0d", got.rect_x, want.rect_x)};
		if (got.rect_y !== want.rect_y)
			msg = {msg, $sformatf(" y %0d/%0d", got.rect_y, want.rect_y)};
		if (got.rect_w !== want.rect_w)
			msg = {msg, $sformatf(" w %0d/%0d", got.rect_w, want.rect_w)};
		if (got.rect_h !== want.rect_h)
			msg = {msg, $sformatf(" h %0d/%0d", got.rect_h, want.rect_h)};
		if (got.rect_color !== want.rect_color)
			msg = {msg, $sformatf(" colour %04h/%04h", got.rect_color, want.rect_color)};
		if (got.visible !== want.visible)
			msg = {msg, $sformatf(" visible %b/%b", got.visible, want.visible)};
		if (got.last !== want.last)
			msg = {msg, $sformatf(" last %b/%b", got.last, want.last)};
		if (msg != "") begin
			msg = $sformatf("rect %0d (got/want):%s", rects_seen - 1, msg);
			return 1'b0;
		end
		return 1'b1;
	endfunction
endclass

module font_glyph_rect_rasterizer_tb;

	// character codes seen by the folding rule
	localparam int unsigned ASCII_SPACE   = 32;
	localparam int unsigned ASCII_UPPER_Z = 90;
	localparam int unsigned ASCII_LOWER_A = 97;
	localparam int unsigned ASCII_LOWER_Z = 122;

	localparam logic [2:0]  ADDR_WIDTH_REG  = {REG_SCREEN_WIDTH, 2'b00};
	localparam logic [2:0]  ADDR_HEIGHT_REG = {REG_SCREEN_HEIGHT, 2'b00};
	localparam logic [31:0] UPPER_BITS      = 32'hFFFF_F800;

	localparam int unsigned LONG_HOLD    = 400;   // receiver hold-off, in cycles
	localparam int unsigned IDLE_LIMIT   = 3000;  // cycles with no word moving
	localparam int unsigned PRINT_LIMIT  = 25;

	// own copy of the 5x7 font, column 0 in the top byte, bit 0 the top row
	localparam logic [39:0] CELL_FONT [59] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
		40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
		40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
		40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
		40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
		40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
		40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
		40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
		40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_41_51_32,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
		40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
		40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
		40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
		40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43
	};

	logic        clk;
	logic        arst_n;
	logic        char_valid;
	logic        char_ready;
	char_word_t  char_word;
	logic        rect_valid;
	logic        rect_ready;
	rect_word_t  rect_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rect_scoreboard sb;
	int unsigned    mismatch_count;
	int unsigned    idle_cycles;
	// long hold-offs asked for by the stimulus and those the receiver has served
	int unsigned    hold_requests;
	int unsigned    hold_served;

	font_glyph_rect_rasterizer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_word  (char_word),
		.rect_valid (rect_valid),
		.rect_ready (rect_ready),
		.rect_word  (rect_word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("MISMATCH: %s", msg);
		end
		mismatch_count++;
	endtask

	// fold lower case to upper, anything outside the printable span draws a space
	function automatic logic [39:0] glyph_of(input logic [7:0] code);
		int unsigned c;
		c = code;
		if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
			c = c - (ASCII_LOWER_A - "A");
		end
		if (c < ASCII_SPACE || c > ASCII_UPPER_Z) begin
			c = ASCII_SPACE;
		end
		return CELL_FONT[c - ASCII_SPACE];
	endfunction

	function automatic char_word_t make_char(input logic [7:0] code, input logic [9:0] x,
			input logic [9:0] y, input logic [15:0] fg, input logic [15:0] bg,
			input logic [7:0] s);
		char_word_t w;
		w.char_code = code;
		w.x_pos     = x;
		w.y_pos     = y;
		w.fg_color  = fg;
		w.bg_color  = bg;
		w.scale     = s;
		return w;
	endfunction

	// pick a coordinate, often close to the display edge so clipping gets exercised
	function automatic logic [9:0] random_coord(input int unsigned limit);
		int t;
		if ($urandom_range(0, 2) == 0 && limit <= 1040) begin
			t = int'(limit) - int'($urandom_range(0, 24));
			if (t < 0) t = 0;
			if (t > 1023) t = 1023;
			return 10'(t);
		end
		return 10'($urandom_range(0, 1023));
	endfunction

	function automatic char_word_t random_char();
		char_word_t w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: w.char_code = 8'($urandom_range(ASCII_SPACE, ASCII_UPPER_Z));
			5, 6:          w.char_code = 8'($urandom_range(ASCII_LOWER_A, ASCII_LOWER_Z));
			default:       w.char_code = 8'($urandom_range(0, 255));
		endcase
		w.x_pos    = random_coord(sb.disp_w);
		w.y_pos    = random_coord(sb.disp_h);
		w.fg_color = 16'($urandom());
		w.bg_color = 16'($urandom());
		// mostly small magnification, now and then the full range
		w.scale    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
		                                         : 8'($urandom_range(0, 6));
		return w;
	endfunction

	// Call at a falling edge; returns at the falling edge after the word is taken,
	// with valid still high so the caller either offers the next word or drops it.
	task automatic send_char(input char_word_t w);
		char_word  <= w;
		char_valid <= 1'b1;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		sb.note_char(w, glyph_of(w.char_code));
		@(negedge clk);
	endtask

	task automatic go_idle();
		char_valid <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every owed rectangle, then let the pipeline run dry
	task automatic settle();
		while (sb.pending() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_check(input logic [2:0] addr, input logic [10:0] want);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		if (got !== {21'b0, want}) begin
			report_mismatch($sformatf("register at %0h reads %0h, want %0h", addr, got, want));
		end
	endtask

	// write both size registers, with junk above bit 10 now and then (always when wide), and read them back
	task automatic set_display(input int unsigned w, input int unsigned h, input bit wide);
		logic [31:0] wd;
		logic [31:0] hd;
		wd = ((wide || $urandom_range(0, 1)) ? ($urandom() & UPPER_BITS) : 32'h0) | 32'(w);
		hd = ((wide || $urandom_range(0, 1)) ? ($urandom() & UPPER_BITS) : 32'h0) | 32'(h);
		if (wide) begin
			wd = wd | UPPER_BITS;
		end
		apb_write(ADDR_WIDTH_REG, wd);
		apb_write(ADDR_HEIGHT_REG, hd);
		sb.set_display(w, h);
		apb_check(ADDR_WIDTH_REG, 11'(w));
		apb_check(ADDR_HEIGHT_REG, 11'(h));
	endtask

	// bursts of words with random gaps; some gaps wait for the block to drain
	task automatic run_random(input int unsigned n);
		int unsigned burst;
		int unsigned sent;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 12);
			if (burst > n - sent) burst = n - sent;
			repeat (burst) send_char(random_char());
			sent += burst;
			case ($urandom_range(0, 9))
				0, 1: ;
				2: begin
					go_idle();
					while (sb.pending() != 0) @(negedge clk);
				end
				default: begin
					go_idle();
					repeat ($urandom_range(0, 40)) @(negedge clk);
				end
			endcase
		end
		go_idle();
	endtask

	// Receiver: ready follows a style that changes every so often; a requested
	// long hold-off overrides it.
	initial begin : rect_sink
		int unsigned style;
		int unsigned left;
		int unsigned beat;
		rect_ready  = 1'b0;
		hold_served = 0;
		style       = 0;
		left        = 0;
		beat        = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				rect_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_served++;
			end else begin
				if (left == 0) begin
					style = $urandom_range(0, 3);
					left  = $urandom_range(40, 200);
				end
				left--;
				beat++;
				case (style)
					0:       rect_ready <= 1'b1;
					1:       rect_ready <= 1'($urandom_range(0, 1));
					2:       rect_ready <= ($urandom_range(0, 9) != 0);
					default: rect_ready <= (beat % 4 != 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin : rect_monitor
		string msg;
		if (arst_n && rect_valid && rect_ready) begin
			if (!sb.check_rect(rect_word, msg)) begin
				report_mismatch(msg);
			end
		end
	end

	// end the run if no word moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (char_valid && char_ready) || (rect_valid && rect_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		sb             = new();
		mismatch_count = 0;
		idle_cycles    = 0;
		hold_requests  = 0;
		arst_n         = 1'b0;
		char_valid     = 1'b0;
		char_word      = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values of the size registers
		apb_check(ADDR_WIDTH_REG, 11'd240);
		apb_check(ADDR_HEIGHT_REG, 11'd320);

		// directed words on the reset-sized display
		send_char(make_char("A", 10'd0, 10'd0, 16'hFFFF, 16'h0000, 8'd1));
		send_char(make_char("a", 10'd20, 10'd30, 16'h0000, 16'hFFFF, 8'd2));
		send_char(make_char("z", 10'd40, 10'd40, 16'hF800, 16'h07E0, 8'd3));
		send_char(make_char(8'd32, 10'd5, 10'd5, 16'h1234, 16'h5678, 8'd1));
		send_char(make_char(8'd90, 10'd100, 10'd100, 16'hAAAA, 16'h5555, 8'd2));
		send_char(make_char(8'd0, 10'd50, 10'd60, 16'hFFFF, 16'h0001, 8'd1));
		send_char(make_char(8'd31, 10'd50, 10'd60, 16'hFFFF, 16'h0002, 8'd1));
		send_char(make_char(8'd91, 10'd50, 10'd60, 16'hFFFF, 16'h0003, 8'd1));
		send_char(make_char(8'd96, 10'd50, 10'd60, 16'hFFFF, 16'h0004, 8'd1));
		send_char(make_char(8'd123, 10'd50, 10'd60, 16'hFFFF, 16'h0005, 8'd1));
		send_char(make_char(8'd255, 10'd50, 10'd60, 16'hFFFF, 16'h0006, 8'd1));
		// zero scale: all rectangles empty
		send_char(make_char("M", 10'd10, 10'd10, 16'hFFFF, 16'h0000, 8'd0));
		// overhang on both edges
		send_char(make_char("#", 10'd230, 10'd310, 16'h001F, 16'hFFE0, 8'd4));
		// wholly off screen
		send_char(make_char("W", 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 8'd255));
		send_char(make_char("8", 10'd1023, 10'd0, 16'h0F0F, 16'hF0F0, 8'd1));
		go_idle();
		settle();

		// largest display
		set_display(2047, 2047, 1'b0);
		send_char(make_char("W", 10'd1023, 10'd1023, 16'hFFFF, 16'h0000, 8'd255));
		send_char(make_char("@", 10'd0, 10'd0, 16'h0000, 16'hFFFF, 8'd255));
		go_idle();
		settle();

		// single-pixel display
		set_display(1, 1, 1'b0);
		send_char(make_char("A", 10'd0, 10'd0, 16'hFFFF, 16'h0000, 8'd1));
		send_char(make_char("A", 10'd0, 10'd0, 16'h0000, 16'hFFFF, 8'd3));
		go_idle();
		settle();

		// zero display size, written with junk above the kept bits
		set_display(0, 0, 1'b1);
		send_char(make_char("H", 10'd0, 10'd0, 16'hFFFF, 16'h0000, 8'd1));
		go_idle();
		settle();

		// back to the usual panel; hold the receiver off while words keep coming
		set_display(240, 320, 1'b0);
		hold_requests++;
		repeat (8) send_char(random_char());
		go_idle();
		run_random(60);
		settle();

		set_display(2047, 2047, 1'b1);
		run_random(60);
		settle();

		// narrow strip; pause halfway until every rectangle has come back
		set_display(1, 2047, 1'b0);
		run_random(30);
		while (sb.pending() != 0) @(negedge clk);
		run_random(30);
		settle();

		set_display(2047, 1, 1'b0);
		run_random(50);
		settle();

		set_display($urandom_range(1, 2047), $urandom_range(1, 2047), 1'b0);
		run_random(60);
		settle();

		set_display($urandom_range(8, 200), $urandom_range(8, 200), 1'b0);
		hold_requests++;
		run_random(60);
		settle();

		set_display(0, $urandom_range(1, 2047), 1'b0);
		run_random(32);
		settle();

		// let any stray rectangle show itself
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			report_mismatch($sformatf("%0d rectangles never arrived", sb.pending()));
		end
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
